// File: rtl/assert_macros.svh
// Assertion macros used by the run-length encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies an expression in the same cycle.
`define ASSERT_IMPLIES(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Check that a condition implies an expression in the following cycle.
`define ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// File: rtl/trle_pkg.sv
// Shared types and constants of the TGA run-length row encoder.
`default_nettype none

package trle_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;
	localparam int PIX_W      = 32;
	localparam int LANES      = 4;
	localparam int HDR_LEN_W  = 7;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT    = CFG_IDX_W'(1);

	// Pixel format codes
	localparam logic [1:0] FMT_GRAY = 2'd0;
	localparam logic [1:0] FMT_BGR  = 2'd1;

	// Run packet flag in the header byte
	localparam logic [7:0] HDR_RUN = 8'h80;

	// One result word as it leaves the sequencer
	typedef struct packed {
		logic                        header_valid;
		logic [7:0]                  header_byte;
		logic [2:0]                  pixel_count;
		logic [LANES-1:0][PIX_W-1:0] words;
	} result_t;

	// Sequencer to output buffer control
	typedef struct packed {
		logic want;
		logic finish;
		logic row_end;
	} seq_ctl_t;

endpackage

`default_nettype wire

// File: rtl/trle_raw_store.sv
// Raw packet pixel store: one write port, one registered read port.
`default_nettype none

module trle_raw_store #(
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [trle_pkg::PIX_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [trle_pkg::PIX_W-1:0] rd_data
);
	import trle_pkg::*;

	logic [PIX_W-1:0] mem_q [DEPTH];

	// Write and read the store; read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/trle_seq.sv
// Packet sequencer: run state, packet planning and raw store drain.
`default_nettype none

module trle_seq #(
	parameter int MAX_PACKET = 128,
	localparam int CW = $clog2(MAX_PACKET + 1),
	localparam int AW = $clog2(MAX_PACKET)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [trle_pkg::PIX_W-1:0] pixel,
	input  logic                       row_end,
	input  logic                       compress_enable,
	input  logic                       can_push,
	output trle_pkg::seq_ctl_t         ctl,
	output trle_pkg::result_t          res,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [trle_pkg::PIX_W-1:0] wr_data,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  logic [trle_pkg::PIX_W-1:0] rd_data
);
	import trle_pkg::*;

	localparam int LW = $clog2(LANES);

	// Phases of one item's work, lowest index first
	localparam int PH_DRAIN_A  = 0;
	localparam int PH_APPEND_A = 1;
	localparam int PH_RUN_A    = 2;
	localparam int PH_APPEND_B = 3;
	localparam int PH_DRAIN_B  = 4;
	localparam int PH_RUN_B    = 5;
	localparam int PH_PASS     = 6;
	localparam int PH_N        = 7;

	localparam logic [CW-1:0] CNT_ONE = CW'(1);
	localparam logic [CW-1:0] CNT_TWO = CW'(2);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PACKET);
	localparam logic [LW-1:0] LANE_LAST = LW'(LANES - 1);

	typedef enum logic [1:0] {S_IDLE, S_DISP, S_DR_READ, S_DR_PUSH} state_t;
	typedef enum logic [2:0] {OP_NONE, OP_DRAIN, OP_APPEND, OP_RUN, OP_PASS} op_t;

	state_t                      state_q;
	logic [PH_N-1:0]             plan_q;
	logic [PIX_W-1:0]            a_val_q;
	logic [PIX_W-1:0]            b_val_q;
	logic [PIX_W-1:0]            pass_val_q;
	logic [HDR_LEN_W-1:0]        hdr_a_q;
	logic [HDR_LEN_W-1:0]        hdr_b_q;
	logic                        row_end_q;
	logic                        any_q;
	logic [CW-1:0]               run_cnt_q;
	logic [PIX_W-1:0]            run_val_q;
	logic [CW-1:0]               raw_cnt_q;
	logic [CW-1:0]               rd_ptr_q;
	logic [LW-1:0]               ln_q;
	logic                        first_q;
	logic                        cap_v_q;
	logic [LW-1:0]               cap_ln_q;
	logic [LANES-1:0][PIX_W-1:0] g_q;

	logic                 eq_run;
	logic                 run_one;
	logic [CW-1:0]        run_inc;
	logic [CW-1:0]        run1;
	logic [CW-1:0]        run_next;
	logic [PIX_W-1:0]     val1;
	logic [PH_N-1:0]      plan_d;
	logic [HDR_LEN_W-1:0] hdr_a_d;
	logic [HDR_LEN_W-1:0] hdr_b_d;
	logic                 flush;
	logic [CW-1:0]        raw_inc;
	logic [CW-1:0]        rd_ptr_inc;
	logic [HDR_LEN_W-1:0] raw_len;
	op_t                  op;
	logic [PH_N-1:0]      op_clr;
	logic [PIX_W-1:0]     op_val;
	logic [HDR_LEN_W-1:0] op_hdr;
	logic                 want;

	assign run_inc    = run_cnt_q + CNT_ONE;
	assign run_one    = (run_cnt_q == CNT_ONE);
	assign eq_run     = (run_cnt_q != '0) && (pixel == run_val_q);
	assign raw_inc    = raw_cnt_q + CNT_ONE;
	assign rd_ptr_inc = rd_ptr_q + CNT_ONE;
	assign raw_len    = HDR_LEN_W'(raw_cnt_q - CNT_ONE);
	assign in_stall   = (state_q != S_IDLE);

	// Plan the packets that the incoming pixel closes
	always_comb begin
		plan_d  = '0;
		run1    = run_cnt_q;
		val1    = run_val_q;
		hdr_a_d = '0;
		hdr_b_d = '0;
		if (compress_enable) begin
			priority if (run_cnt_q == '0) begin
				run1 = CNT_ONE;
				val1 = pixel;
			end else if (eq_run) begin
				plan_d[PH_DRAIN_A] = run_one;
				if (run_inc == CNT_MAX) begin
					plan_d[PH_RUN_A] = 1'b1;
					hdr_a_d          = HDR_LEN_W'(run_cnt_q);
					run1             = '0;
				end else begin
					run1 = run_inc;
				end
			end else begin
				if (run_one) begin
					plan_d[PH_APPEND_A] = 1'b1;
				end else begin
					plan_d[PH_RUN_A] = 1'b1;
					hdr_a_d          = HDR_LEN_W'(run_cnt_q - CNT_ONE);
				end
				run1 = CNT_ONE;
				val1 = pixel;
			end
		end
		flush    = !compress_enable || row_end;
		run_next = run1;
		if (flush) begin
			plan_d[PH_APPEND_B] = (run1 == CNT_ONE);
			plan_d[PH_DRAIN_B]  = 1'b1;
			plan_d[PH_RUN_B]    = (run1 >= CNT_TWO);
			hdr_b_d             = HDR_LEN_W'(run1 - CNT_ONE);
			run_next            = '0;
		end
		plan_d[PH_PASS] = !compress_enable;
	end

	// Pick the next pending phase
	always_comb begin
		op     = OP_NONE;
		op_clr = '0;
		op_val = a_val_q;
		op_hdr = hdr_a_q;
		priority if (plan_q[PH_DRAIN_A]) begin
			op                 = OP_DRAIN;
			op_clr[PH_DRAIN_A] = 1'b1;
		end else if (plan_q[PH_APPEND_A]) begin
			op                  = OP_APPEND;
			op_clr[PH_APPEND_A] = 1'b1;
		end else if (plan_q[PH_RUN_A]) begin
			op               = OP_RUN;
			op_clr[PH_RUN_A] = 1'b1;
		end else if (plan_q[PH_APPEND_B]) begin
			op                  = OP_APPEND;
			op_clr[PH_APPEND_B] = 1'b1;
			op_val              = b_val_q;
		end else if (plan_q[PH_DRAIN_B]) begin
			op                 = OP_DRAIN;
			op_clr[PH_DRAIN_B] = 1'b1;
		end else if (plan_q[PH_RUN_B]) begin
			op               = OP_RUN;
			op_clr[PH_RUN_B] = 1'b1;
			op_val           = b_val_q;
			op_hdr           = hdr_b_q;
		end else if (plan_q[PH_PASS]) begin
			op              = OP_PASS;
			op_clr[PH_PASS] = 1'b1;
			op_val          = pass_val_q;
		end else begin
			op = OP_NONE;
		end
	end

	// Drive the store ports and the result word
	always_comb begin
		res   = '0;
		want  = 1'b0;
		wr_en = 1'b0;
		rd_en = 1'b0;
		unique case (state_q)
			S_DISP: begin
				unique case (op)
					OP_APPEND: begin
						wr_en = 1'b1;
					end
					OP_RUN: begin
						want             = 1'b1;
						res.header_valid = 1'b1;
						res.header_byte  = HDR_RUN | {1'b0, op_hdr};
						res.pixel_count  = 3'd1;
						res.words[0]     = op_val;
					end
					OP_PASS: begin
						want            = 1'b1;
						res.pixel_count = 3'd1;
						res.words[0]    = op_val;
					end
					default: begin
					end
				endcase
			end
			S_DR_READ: begin
				rd_en = 1'b1;
			end
			S_DR_PUSH: begin
				want             = 1'b1;
				res.header_valid = first_q;
				res.header_byte  = first_q ? {1'b0, raw_len} : 8'd0;
				res.pixel_count  = 3'(cap_ln_q) + 3'd1;
				for (int k = 0; k < LANES; k++) begin
					if (LW'(k) == cap_ln_q) begin
						res.words[k] = rd_data;
					end else if (LW'(k) < cap_ln_q) begin
						res.words[k] = g_q[k];
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_addr     = raw_cnt_q[AW-1:0];
	assign wr_data     = op_val;
	assign rd_addr     = rd_ptr_q[AW-1:0];
	assign ctl.want    = want;
	assign ctl.finish  = (state_q == S_DISP) && (op == OP_NONE) && any_q;
	assign ctl.row_end = row_end_q;

	// Hold state, run registers and drain progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			plan_q     <= '0;
			a_val_q    <= '0;
			b_val_q    <= '0;
			pass_val_q <= '0;
			hdr_a_q    <= '0;
			hdr_b_q    <= '0;
			row_end_q  <= 1'b0;
			any_q      <= 1'b0;
			run_cnt_q  <= '0;
			run_val_q  <= '0;
			raw_cnt_q  <= '0;
			rd_ptr_q   <= '0;
			ln_q       <= '0;
			first_q    <= 1'b0;
			cap_v_q    <= 1'b0;
			cap_ln_q   <= '0;
			g_q        <= '0;
		end else begin
			// Read data is valid in the cycle after a read cycle
			cap_v_q <= (state_q == S_DR_READ);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						plan_q     <= plan_d;
						a_val_q    <= run_val_q;
						b_val_q    <= val1;
						pass_val_q <= pixel;
						hdr_a_q    <= hdr_a_d;
						hdr_b_q    <= hdr_b_d;
						row_end_q  <= row_end;
						run_cnt_q  <= run_next;
						run_val_q  <= val1;
						if (plan_d != '0) begin
							state_q <= S_DISP;
						end
					end
				end
				S_DISP: begin
					unique case (op)
						OP_DRAIN: begin
							plan_q <= plan_q & ~op_clr;
							if (raw_cnt_q != '0) begin
								state_q  <= S_DR_READ;
								rd_ptr_q <= '0;
								ln_q     <= '0;
								first_q  <= 1'b1;
							end
						end
						OP_APPEND: begin
							plan_q    <= plan_q & ~op_clr;
							raw_cnt_q <= raw_inc;
							// A full packet drains at once
							if (raw_inc == CNT_MAX) begin
								state_q  <= S_DR_READ;
								rd_ptr_q <= '0;
								ln_q     <= '0;
								first_q  <= 1'b1;
							end
						end
						OP_RUN, OP_PASS: begin
							if (can_push) begin
								plan_q <= plan_q & ~op_clr;
								any_q  <= 1'b1;
							end
						end
						default: begin
							any_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_DR_READ: begin
					cap_ln_q <= ln_q;
					rd_ptr_q <= rd_ptr_inc;
					ln_q     <= ln_q + LW'(1);
					if (cap_v_q) begin
						g_q[cap_ln_q] <= rd_data;
					end
					if ((ln_q == LANE_LAST) || (rd_ptr_inc == raw_cnt_q)) begin
						state_q <= S_DR_PUSH;
					end
				end
				S_DR_PUSH: begin
					if (can_push) begin
						any_q   <= 1'b1;
						first_q <= 1'b0;
						ln_q    <= '0;
						if (rd_ptr_q == raw_cnt_q) begin
							raw_cnt_q <= '0;
							state_q   <= S_DISP;
						end else begin
							state_q <= S_DR_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/trle_out_buf.sv
// Result hold stage and output register with burst and row marking.
`default_nettype none

module trle_out_buf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  trle_pkg::seq_ctl_t         ctl,
	input  trle_pkg::result_t          res,
	output logic                       can_push,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       header_valid,
	output logic [7:0]                 header_byte,
	output logic [2:0]                 pixel_count,
	output logic [trle_pkg::PIX_W-1:0] word0,
	output logic [trle_pkg::PIX_W-1:0] word1,
	output logic [trle_pkg::PIX_W-1:0] word2,
	output logic [trle_pkg::PIX_W-1:0] word3,
	output logic                       row_done,
	output logic                       burst_end
);
	import trle_pkg::*;

	result_t h_res_q;
	result_t o_res_q;
	logic    h_valid_q;
	logic    h_last_q;
	logic    h_row_q;
	logic    o_valid_q;
	logic    o_last_q;
	logic    o_row_q;
	logic    out_free;
	logic    hold_move;
	logic    push;

	// A held word moves on once it is known whether it closes the burst
	assign out_free  = !o_valid_q || !out_stall;
	assign hold_move = h_valid_q && out_free && (ctl.want || h_last_q);
	assign can_push  = !h_valid_q || out_free;
	assign push      = ctl.want && can_push;

	// Advance the hold and output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_q <= 1'b0;
			h_last_q  <= 1'b0;
			h_row_q   <= 1'b0;
			o_valid_q <= 1'b0;
			o_last_q  <= 1'b0;
			o_row_q   <= 1'b0;
		end else begin
			if (hold_move) begin
				o_valid_q <= 1'b1;
				o_last_q  <= h_last_q;
				o_row_q   <= h_row_q;
			end else if (o_valid_q && !out_stall) begin
				o_valid_q <= 1'b0;
			end
			if (push) begin
				h_valid_q <= 1'b1;
				h_last_q  <= 1'b0;
				h_row_q   <= 1'b0;
			end else if (hold_move) begin
				h_valid_q <= 1'b0;
			end
			// Mark the last word of the item
			if (ctl.finish) begin
				h_last_q <= 1'b1;
				h_row_q  <= ctl.row_end;
			end
		end
	end

	// Load payload
	always_ff @(posedge clk) begin
		if (push) begin
			h_res_q <= res;
		end
		if (hold_move) begin
			o_res_q <= h_res_q;
		end
	end

	assign out_valid    = o_valid_q;
	assign header_valid = o_res_q.header_valid;
	assign header_byte  = o_res_q.header_byte;
	assign pixel_count  = o_res_q.pixel_count;
	assign word0        = o_res_q.words[0];
	assign word1        = o_res_q.words[1];
	assign word2        = o_res_q.words[2];
	assign word3        = o_res_q.words[3];
	assign row_done     = o_row_q;
	assign burst_end    = o_last_q;

endmodule

`default_nettype wire

// File: rtl/tga_rle_row_encoder.sv
// Top level of the TGA run-length row encoder.
//
// Channel   Direction  Handshake             Word
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in        in         in_valid/in_stall     red, green, blue, alpha, row_end
// out       out        out_valid/out_stall   header, pixel_count, word0..3, flags
//
// A pixel that opens a run, or extends one of two or more pixels below the packet
// limit and ends no row, is taken at once. Any other pixel dispatches its planned
// steps (append, drain, run word, pass-through word) in turn, and a closing step
// marks the end of its burst if it pushed a word. A raw drain reads one pixel a
// cycle on the single store read port and pushes each word as the output takes
// it. Reset clears run state and flags, never the store; output stalls back up.
`default_nettype none
`include "assert_macros.svh"

module tga_rle_row_encoder #(
	parameter int MAX_PACKET = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [trle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trle_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      red,
	input  logic [7:0]                      green,
	input  logic [7:0]                      blue,
	input  logic [7:0]                      alpha,
	input  logic                            row_end,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            header_valid,
	output logic [7:0]                      header_byte,
	output logic [2:0]                      pixel_count,
	output logic [31:0]                     word0,
	output logic [31:0]                     word1,
	output logic [31:0]                     word2,
	output logic [31:0]                     word3,
	output logic                            row_done,
	output logic                            burst_end
);
	import trle_pkg::*;

	localparam int AW = $clog2(MAX_PACKET);

	logic             compress_en_q;
	logic [1:0]       pixel_format_q;
	logic [PIX_W-1:0] pixel;
	logic             can_push;
	seq_ctl_t         ctl;
	result_t          res;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [PIX_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [PIX_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	// Take register writes; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compress_en_q  <= 1'b1;
			pixel_format_q <= FMT_BGR;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_COMPRESS_ENABLE) begin
				compress_en_q <= cfg_data[0];
			end else if (cfg_index == CFG_PIXEL_FORMAT) begin
				pixel_format_q <= cfg_data[1:0];
			end
		end
	end

	// Pack the pixel in file byte order
	always_comb begin
		unique case (pixel_format_q)
			FMT_GRAY: pixel = {24'd0, red};
			FMT_BGR:  pixel = {8'd0, red, green, blue};
			default:  pixel = {alpha, red, green, blue};
		endcase
	end

	trle_seq #(
		.MAX_PACKET(MAX_PACKET)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pixel           (pixel),
		.row_end         (row_end),
		.compress_enable (compress_en_q),
		.can_push        (can_push),
		.ctl             (ctl),
		.res             (res),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data)
	);

	trle_raw_store #(
		.DEPTH(MAX_PACKET)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	trle_out_buf u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.res          (res),
		.can_push     (can_push),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.header_valid (header_valid),
		.header_byte  (header_byte),
		.pixel_count  (pixel_count),
		.word0        (word0),
		.word1        (word1),
		.word2        (word2),
		.word3        (word3),
		.row_done     (row_done),
		.burst_end    (burst_end)
	);

	// A run packet carries exactly one pixel
	`ASSERT_IMPLIES(a_run_one_pixel, out_valid && header_valid && header_byte[7], pixel_count == 3'd1, "run packet with more than one pixel")
	// Every word carries one to four pixels
	`ASSERT_IMPLIES(a_count_range, out_valid, (pixel_count != 3'd0) && (pixel_count <= 3'(LANES)), "pixel count out of range")
	// Row completion only on the last word of a burst
	`ASSERT_IMPLIES(a_row_done_last, out_valid && row_done, burst_end, "row done before end of burst")
	// A pass-through pixel always keeps the sequencer busy next cycle
	`ASSERT_NEXT(a_pass_busy, in_valid && !in_stall && !compress_en_q, in_stall, "pass-through pixel produced no work")

endmodule

`default_nettype wire
